// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked and disabled while reset is applied.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hkfc_pkg.sv -----
// ----------------------------------------------------------------------------
// hkfc_pkg
// Types and constants of the hashed key frequency counter.
// ----------------------------------------------------------------------------
package hkfc_pkg;

  // Table size, any value from 1 to 65536
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned COUNT_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [IDX_W-1:0]   LAST_SLOT = IDX_W'(CAPACITY - 1);

  // Home slot is a plain bit slice when the capacity is a power of two
  localparam bit CAP_POW2 = (CAPACITY > 1) && ((CAPACITY & (CAPACITY - 1)) == 0);

  // Remainder unit: key bits consumed per cycle
  localparam int unsigned DIGIT_BITS = 8;
  localparam int unsigned HASH_STEPS = KEY_W / DIGIT_BITS;
  localparam int unsigned STEP_W     = $clog2(HASH_STEPS);

  // Commands
  localparam logic CMD_BUMP = 1'b0;
  localparam logic CMD_GET  = 1'b1;

  // One table slot; a zero count marks it empty
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } slot_t;

endpackage

// ----- hdl/hkfc_ram.sv -----
// ----------------------------------------------------------------------------
// hkfc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hkfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/hkfc_home.sv -----
// ----------------------------------------------------------------------------
// hkfc_home
// Home slot of a key: key modulo the capacity. A bit slice for a power-of-two
// capacity, otherwise a restoring remainder over the key bits.
// ----------------------------------------------------------------------------
module hkfc_home
  import hkfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [IDX_W-1:0] slot
);

  generate
    if (CAP_POW2) begin : g_slice
      logic             done_r;
      logic [IDX_W-1:0] slot_r;

      // Low bits of the key are the remainder
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          slot_r <= key[IDX_W-1:0];
        end
      end

      assign done = done_r;
      assign slot = slot_r;

    end else begin : g_serial
      localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(CAPACITY);

      logic              run_r;
      logic              done_r;
      logic [STEP_W-1:0] step_r;
      logic [KEY_W-1:0]  key_r;
      logic [IDX_W-1:0]  rem_r;
      logic [IDX_W-1:0]  rem_nxt;

      // One digit of key bits a cycle, MSB first; remainder stays below capacity
      always_comb begin
        logic [IDX_W:0]   t;
        logic [IDX_W-1:0] r;
        r = rem_r;
        for (int b = 0; b < DIGIT_BITS; b++) begin
          t = {r, key_r[KEY_W-1-b]};
          if (t >= CAP_EXT) begin
            t = t - CAP_EXT;
          end
          r = t[IDX_W-1:0];
        end
        rem_nxt = r;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          run_r  <= 1'b0;
          done_r <= 1'b0;
          step_r <= '0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            run_r  <= 1'b1;
            step_r <= '0;
          end else if (run_r) begin
            step_r <= step_r + 1'b1;
            if (step_r == STEP_W'(HASH_STEPS - 1)) begin
              run_r  <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
        // Datapath
        if (start) begin
          key_r <= key;
          rem_r <= '0;
        end else if (run_r) begin
          key_r <= key_r << DIGIT_BITS;
          rem_r <= rem_nxt;
        end
      end

      assign done = done_r;
      assign slot = rem_r;
    end
  endgenerate

endmodule

// ----- hdl/hashed_key_frequency_counter.sv -----
// ----------------------------------------------------------------------------
// hashed_key_frequency_counter
// Open-addressed table of key counters with linear probing, held in one RAM.
//
//   Channel   Ports                      Handshake
//   input     in_cmd, in_key             beat taken when start && !busy
//   result    out_count                  one-cycle strobe on out_valid
//
// An item passes through HASH, PROBE and EVAL when its key sits in or claims
// its home slot, with a further EVAL for each further slot probed: the probe
// reads one slot per cycle from the table RAM, whose read data is registered.
// A capacity that is not a power of two lengthens HASH by the remainder unit
// that finds the home slot. After reset a clearing pass writes every slot
// empty, one a cycle; busy is high throughout. The result strobe cannot be
// stalled, and the next beat is taken while the result is on the ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hashed_key_frequency_counter
  import hkfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic [KEY_W-1:0]   in_key,
  output logic               out_valid,
  output logic [COUNT_W-1:0] out_count
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_EVAL
  } state_t;

  state_t             state_r;
  logic [IDX_W-1:0]   clr_idx_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   idx_nxt;
  logic [IDX_W-1:0]   probes_r;
  logic               cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               accept;
  logic               home_done;
  logic [IDX_W-1:0]   home_slot;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  slot_t              ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  slot_t              ram_rdata;

  logic               slot_empty;
  logic               slot_hit;
  logic               finish;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W-1:0] count_nxt_past;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Home slot of the incoming key
  hkfc_home u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (in_key),
    .done  (home_done),
    .slot  (home_slot)
  );

  // Slot table
  hkfc_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Probe evaluation on the slot read last cycle
  assign idx_nxt    = (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;
  assign slot_empty = (ram_rdata.count == '0);
  assign slot_hit   = !slot_empty && (ram_rdata.key == key_r);
  assign finish     = slot_empty || slot_hit || (probes_r == LAST_SLOT);
  assign count_inc  = (ram_rdata.count == COUNT_MAX) ? COUNT_MAX
                                                      : ram_rdata.count + 1'b1;

  // Result of the item when the probe ends here
  always_comb begin
    count_nxt = '0;
    if (slot_empty) begin
      count_nxt = (cmd_r == CMD_BUMP) ? COUNT_W'(1) : '0;
    end else if (slot_hit) begin
      count_nxt = (cmd_r == CMD_BUMP) ? count_inc : ram_rdata.count;
    end
  end

  // Table access: clearing writes, probe reads, bump write-back.
  // A write lands at the end of EVAL, before the next item's first read.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = idx_r;
    ram_wdata.key   = key_r;
    ram_wdata.count = count_nxt;
    ram_raddr       = idx_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
      end
      ST_EVAL: begin
        // next slot read ahead in case this one misses
        ram_raddr = idx_nxt;
        ram_we    = (cmd_r == CMD_BUMP) && (slot_empty || slot_hit);
      end
      ST_IDLE, ST_HASH, ST_PROBE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == LAST_SLOT) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (home_done) begin
            state_r <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (finish) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    // Datapath
    if (accept) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
    end
    if (state_r == ST_HASH && home_done) begin
      idx_r    <= home_slot;
      probes_r <= '0;
    end else if (state_r == ST_EVAL && !finish) begin
      idx_r    <= idx_nxt;
      probes_r <= probes_r + 1'b1;
    end
    if (state_r == ST_EVAL && finish) begin
      out_count_r <= count_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

  // Copy of the result being registered, for the result check
  always_ff @(posedge clk) begin
    count_nxt_past <= count_nxt;
  end

  // Checks
  `ASSERT_NEXT(a_result_on_finish, clk, rst_n,
               (state_r == ST_EVAL) && finish, out_valid && (out_count == count_nxt_past),
               "probe end did not deliver its result")
  `ASSERT_IMPL(a_get_no_write, clk, rst_n,
               (state_r == ST_EVAL) && (cmd_r == CMD_GET), !ram_we,
               "read command wrote the table")
  `ASSERT_NEXT(a_claim_gives_one, clk, rst_n,
               (state_r == ST_EVAL) && slot_empty && (cmd_r == CMD_BUMP),
               out_valid && (out_count == COUNT_W'(1)),
               "claim of an empty slot did not return one")
  `ASSERT_IMPL(a_no_result_while_busy_clear, clk, rst_n,
               (state_r == ST_CLEAR), !out_valid && ram_we,
               "result or missing write during clearing pass")

endmodule
